FILE: hw/rtl/tlic_pkg.sv
package tlic_pkg;

   localparam int ADDR_PORT_BITS = 26;

   typedef logic [1:0] policy_type;

   localparam policy_type POL_LRU   = 2'd0;
   localparam policy_type POL_SRRIP = 2'd1;
   localparam policy_type POL_NRU   = 2'd2;

   localparam logic [1:0] RRPV_MAX    = 2'd3;
   localparam logic [1:0] RRPV_INSERT = 2'd2;
   localparam logic [1:0] RRPV_HIT    = 2'd0;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_LOOK  = 5'b00100,
      S_INV   = 5'b01000,
      S_FILL  = 5'b10000
   } state_type;

endpackage

FILE: hw/rtl/tlic_far_ctl.sv
module tlic_far_ctl #(
   parameter int FAR_WAYS = 16,
   parameter int FTW      = 16,
   parameter int FRB      = 4,
   parameter int FCW      = 5
) (
   input  tlic_pkg::policy_type             policy,
   input  logic [FTW-1:0]                   tag,
   input  logic [FAR_WAYS-1:0][FTW-1:0]     tags_i,
   input  logic [FAR_WAYS-1:0]              valid_i,
   input  logic [FAR_WAYS-1:0][FRB-1:0]     ranks_i,
   input  logic [FAR_WAYS-1:0][1:0]         rrpv_i,
   input  logic [FAR_WAYS-1:0]              refs_i,
   input  logic [FCW-1:0]                   count_i,
   output logic                             hit,
   output logic                             victim_valid,
   output logic [FTW-1:0]                   victim_tag,
   output logic [FAR_WAYS-1:0][FTW-1:0]     tags_o,
   output logic [FAR_WAYS-1:0]              valid_o,
   output logic [FAR_WAYS-1:0][FRB-1:0]     ranks_o,
   output logic [FAR_WAYS-1:0][1:0]         rrpv_o,
   output logic [FAR_WAYS-1:0]              refs_o,
   output logic [FCW-1:0]                   count_o
);

   localparam int FWI = $clog2(FAR_WAYS);

   logic [FAR_WAYS-1:0] hit_vec;
   logic [FWI-1:0]      hit_way;
   logic                inv_found;
   logic [FWI-1:0]      inv_way;
   logic [1:0]          rmax;
   logic [1:0]          age;
   logic [FWI-1:0]      srrip_way;
   logic [FWI-1:0]      nru_way;
   logic [FWI-1:0]      lru_way;
   logic [FWI-1:0]      way;
   logic [1:0]          ins;
   logic [FRB-1:0]      rsel;
   logic [FCW-1:0]      cnt;

   always_comb begin
      hit_way   = '0;
      inv_found = 1'b0;
      inv_way   = '0;
      srrip_way = '0;
      nru_way   = '0;
      lru_way   = '0;
      rmax[1]   = 1'b0;
      rmax[0]   = 1'b0;
      for (int w = 0; w < FAR_WAYS; w++) begin
         hit_vec[w] = valid_i[w] && (tags_i[w] == tag);
         rmax[1]    = rmax[1] | rrpv_i[w][1];
      end
      for (int w = 0; w < FAR_WAYS; w++) begin
         rmax[0] = rmax[0] | (rrpv_i[w][0] & (rrpv_i[w][1] == rmax[1]));
      end
      for (int w = FAR_WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) hit_way = FWI'(w);
         if (!valid_i[w]) begin
            inv_found = 1'b1;
            inv_way   = FWI'(w);
         end
         if (rrpv_i[w] == rmax) srrip_way = FWI'(w);
         if (!refs_i[w]) nru_way = FWI'(w);
         if (ranks_i[w] == FRB'(FAR_WAYS - 1)) lru_way = FWI'(w);
      end
      hit          = |hit_vec;
      age          = tlic_pkg::RRPV_MAX - rmax;
      victim_valid = 1'b0;
      victim_tag   = '0;
      tags_o       = tags_i;
      valid_o      = valid_i;
      ranks_o      = ranks_i;
      rrpv_o       = rrpv_i;
      refs_o       = refs_i;
      count_o      = count_i;
      ins          = tlic_pkg::RRPV_INSERT;
      way          = inv_way;
      if (hit) begin
         way = hit_way;
         ins = tlic_pkg::RRPV_HIT;
      end else begin
         if (!inv_found) begin
            case (policy)
               tlic_pkg::POL_SRRIP: begin
                  way = srrip_way;
                  for (int w = 0; w < FAR_WAYS; w++) begin
                     rrpv_o[w] = rrpv_i[w] + age;
                  end
               end
               tlic_pkg::POL_NRU: way = nru_way;
               default: way = lru_way;
            endcase
            victim_valid = 1'b1;
            victim_tag   = tags_i[way];
            refs_o[way]  = 1'b0;
         end
         tags_o[way]  = tag;
         valid_o[way] = 1'b1;
      end
      rsel = ranks_o[way];
      cnt  = count_o + FCW'(!refs_o[way]);
      case (policy)
         tlic_pkg::POL_SRRIP: rrpv_o[way] = ins;
         tlic_pkg::POL_NRU: begin
            if (cnt >= FCW'(FAR_WAYS)) begin
               cnt    = FCW'(1);
               refs_o = '0;
            end
            refs_o[way] = 1'b1;
            count_o     = cnt;
         end
         default: begin
            for (int w = 0; w < FAR_WAYS; w++) begin
               if (ranks_o[w] < rsel) ranks_o[w] = ranks_o[w] + FRB'(1);
            end
            ranks_o[way] = '0;
         end
      endcase
   end

endmodule

FILE: hw/rtl/two_level_inclusive_cache_sim.sv
// The result is registered from the LOOK state for an L1 hit or a fill without an L2
// eviction, from INV when an L2 eviction back-invalidates the same L1 set, else from FILL after INV.
// A new item is taken only in idle: busy stays high from accept through the read and the
// write-back of the tag rows until the result.
// Reset: synchronous; a clearing pass over every L1 and L2 set row follows with busy high.
// The receiver cannot stall: each result is on the rsp_ ports for one cycle.
module two_level_inclusive_cache_sim #(
   parameter int NEAR_SETS = 128,
   parameter int NEAR_WAYS = 8,
   parameter int FAR_SETS  = 1024,
   parameter int FAR_WAYS  = 16,
   parameter int ADDR_BITS = 26
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [tlic_pkg::ADDR_PORT_BITS-1:0]   req_block_address,
   output logic                                  rsp_valid,
   output logic                                  rsp_l1_hit,
   output logic                                  rsp_l2_hit,
   output logic                                  rsp_victim_valid,
   output logic [tlic_pkg::ADDR_PORT_BITS-1:0]   rsp_victim_address,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [1:0]                            csr_data
);

   localparam int NSB  = $clog2(NEAR_SETS);
   localparam int FSB  = $clog2(FAR_SETS);
   localparam int NIW  = (NSB > 0) ? NSB : 1;
   localparam int FIW  = (FSB > 0) ? FSB : 1;
   localparam int NTW  = (ADDR_BITS > NSB) ? ADDR_BITS - NSB : 1;
   localparam int FTW  = (ADDR_BITS > FSB) ? ADDR_BITS - FSB : 1;
   localparam int NRB  = (NEAR_WAYS > 1) ? $clog2(NEAR_WAYS) : 1;
   localparam int FRB  = $clog2(FAR_WAYS);
   localparam int FCW  = $clog2(FAR_WAYS + 1);
   localparam int MAXS = (NEAR_SETS > FAR_SETS) ? NEAR_SETS : FAR_SETS;
   localparam int CLW  = $clog2(MAXS) + 1;

   typedef struct packed {
      logic [NEAR_WAYS-1:0][NTW-1:0] tag;
      logic [NEAR_WAYS-1:0]          valid;
      logic [NEAR_WAYS-1:0][NRB-1:0] rank;
   } near_row_type;

   typedef struct packed {
      logic [FAR_WAYS-1:0][FTW-1:0] tag;
      logic [FAR_WAYS-1:0]          valid;
      logic [FAR_WAYS-1:0][FRB-1:0] rank;
      logic [FAR_WAYS-1:0][1:0]     rrpv;
      logic [FAR_WAYS-1:0]          refs;
      logic [FCW-1:0]               count;
   } far_row_type;

   near_row_type near_mem [NEAR_SETS];
   far_row_type  far_mem  [FAR_SETS];

   tlic_pkg::state_type  state_ff, state_in;
   tlic_pkg::policy_type policy_ff, policy_in;
   logic [CLW-1:0]       clr_ff, clr_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic [ADDR_BITS-1:0] vaddr_ff, vaddr_in;
   near_row_type         rd_near_ff, nrow_ff, nrow_in;
   far_row_type          rd_far_ff;
   logic                 l2hit_ff, l2hit_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_l1_ff, rsp_l1_in;
   logic                 rsp_l2_ff, rsp_l2_in;
   logic                 rsp_vv_ff, rsp_vv_in;
   logic [ADDR_BITS-1:0] rsp_va_ff, rsp_va_in;

   logic                 nrd_en, nwr_en, frd_en, fwr_en;
   logic [NIW-1:0]       nrd_addr, nwr_addr;
   logic [FIW-1:0]       frd_addr, fwr_addr;
   near_row_type         nwr_data, near_clear, near_touch, inv_row, fsrc, fill_row;
   far_row_type          fwr_data, far_clear, far_new;
   logic [ADDR_BITS-1:0] addr_req;
   logic [NIW-1:0]       nset, vset;
   logic [NTW-1:0]       ntag, vtag;
   logic [FIW-1:0]       fset;
   logic [FTW-1:0]       ftag;
   logic                 near_hit, near_inv_found;
   logic [NRB-1:0]       near_hit_way, near_inv_way, near_old_way, fway;
   logic [NRB-1:0]       rsel, fsel;
   logic                 far_hit, far_vv;
   logic [FTW-1:0]       far_vtag;
   logic [ADDR_BITS-1:0] vaddr_new;

   assign addr_req = ADDR_BITS'(64'(req_block_address));
   assign nset     = NIW'(addr_ff % NEAR_SETS);
   assign ntag     = NTW'(addr_ff / NEAR_SETS);
   assign fset     = FIW'(addr_ff % FAR_SETS);
   assign ftag     = FTW'(addr_ff / FAR_SETS);
   assign vset     = NIW'(vaddr_ff % NEAR_SETS);
   assign vtag     = NTW'(vaddr_ff / NEAR_SETS);
   assign vaddr_new = (ADDR_BITS'(far_vtag) << FSB) | ADDR_BITS'(fset);

   tlic_far_ctl #(
      .FAR_WAYS (FAR_WAYS),
      .FTW      (FTW),
      .FRB      (FRB),
      .FCW      (FCW)
   ) u_far_ctl (
      .policy       (policy_ff),
      .tag          (ftag),
      .tags_i       (rd_far_ff.tag),
      .valid_i      (rd_far_ff.valid),
      .ranks_i      (rd_far_ff.rank),
      .rrpv_i       (rd_far_ff.rrpv),
      .refs_i       (rd_far_ff.refs),
      .count_i      (rd_far_ff.count),
      .hit          (far_hit),
      .victim_valid (far_vv),
      .victim_tag   (far_vtag),
      .tags_o       (far_new.tag),
      .valid_o      (far_new.valid),
      .ranks_o      (far_new.rank),
      .rrpv_o       (far_new.rrpv),
      .refs_o       (far_new.refs),
      .count_o      (far_new.count)
   );

   always_comb begin
      near_clear.tag   = '0;
      near_clear.valid = '0;
      far_clear.tag    = '0;
      far_clear.valid  = '0;
      far_clear.rrpv   = '0;
      far_clear.refs   = '0;
      far_clear.count  = '0;
      for (int w = 0; w < NEAR_WAYS; w++) near_clear.rank[w] = NRB'(w);
      for (int w = 0; w < FAR_WAYS; w++) far_clear.rank[w] = FRB'(w);
   end

   always_comb begin
      near_hit_way   = '0;
      near_inv_found = 1'b0;
      near_inv_way   = '0;
      near_old_way   = '0;
      near_hit       = 1'b0;
      inv_row        = rd_near_ff;
      for (int w = NEAR_WAYS - 1; w >= 0; w--) begin
         if (rd_near_ff.valid[w] && rd_near_ff.tag[w] == ntag) begin
            near_hit     = 1'b1;
            near_hit_way = NRB'(w);
         end
         if (rd_near_ff.valid[w] && rd_near_ff.tag[w] == vtag) inv_row.valid[w] = 1'b0;
      end
      near_touch = rd_near_ff;
      rsel       = rd_near_ff.rank[near_hit_way];
      for (int w = 0; w < NEAR_WAYS; w++) begin
         if (rd_near_ff.rank[w] < rsel) near_touch.rank[w] = rd_near_ff.rank[w] + NRB'(1);
      end
      near_touch.rank[near_hit_way] = '0;

      case (state_ff)
         tlic_pkg::S_INV:  fsrc = inv_row;
         tlic_pkg::S_FILL: fsrc = nrow_ff;
         default:          fsrc = rd_near_ff;
      endcase
      for (int w = NEAR_WAYS - 1; w >= 0; w--) begin
         if (!fsrc.valid[w]) begin
            near_inv_found = 1'b1;
            near_inv_way   = NRB'(w);
         end
         if (fsrc.rank[w] == NRB'(NEAR_WAYS - 1)) near_old_way = NRB'(w);
      end
      fway     = near_inv_found ? near_inv_way : near_old_way;
      fill_row = fsrc;
      fill_row.tag[fway]   = ntag;
      fill_row.valid[fway] = 1'b1;
      fsel = fsrc.rank[fway];
      for (int w = 0; w < NEAR_WAYS; w++) begin
         if (fsrc.rank[w] < fsel) fill_row.rank[w] = fsrc.rank[w] + NRB'(1);
      end
      fill_row.rank[fway] = '0;
   end

   always_comb begin
      state_in     = state_ff;
      policy_in    = policy_ff;
      clr_in       = clr_ff;
      addr_in      = addr_ff;
      vaddr_in     = vaddr_ff;
      nrow_in      = nrow_ff;
      l2hit_in     = l2hit_ff;
      rsp_valid_in = 1'b0;
      rsp_l1_in    = rsp_l1_ff;
      rsp_l2_in    = rsp_l2_ff;
      rsp_vv_in    = rsp_vv_ff;
      rsp_va_in    = rsp_va_ff;
      nrd_en       = 1'b0;
      nrd_addr     = nset;
      nwr_en       = 1'b0;
      nwr_addr     = nset;
      nwr_data     = fill_row;
      frd_en       = 1'b0;
      frd_addr     = fset;
      fwr_en       = 1'b0;
      fwr_addr     = fset;
      fwr_data     = far_new;
      if (csr_valid) policy_in = csr_data;
      case (state_ff)
         tlic_pkg::S_CLEAR: begin
            nwr_en   = (clr_ff < CLW'(NEAR_SETS));
            nwr_addr = clr_ff[NIW-1:0];
            nwr_data = near_clear;
            fwr_en   = (clr_ff < CLW'(FAR_SETS));
            fwr_addr = clr_ff[FIW-1:0];
            fwr_data = far_clear;
            clr_in   = clr_ff + CLW'(1);
            if (clr_ff == CLW'(MAXS - 1)) state_in = tlic_pkg::S_IDLE;
         end
         tlic_pkg::S_IDLE: begin
            if (start) begin
               addr_in  = addr_req;
               nrd_en   = 1'b1;
               nrd_addr = NIW'(addr_req % NEAR_SETS);
               frd_en   = 1'b1;
               frd_addr = FIW'(addr_req % FAR_SETS);
               state_in = tlic_pkg::S_LOOK;
            end
         end
         tlic_pkg::S_LOOK: begin
            rsp_l1_in = near_hit;
            rsp_l2_in = !near_hit && far_hit;
            rsp_vv_in = 1'b0;
            rsp_va_in = '0;
            if (near_hit) begin
               nwr_en       = 1'b1;
               nwr_data     = near_touch;
               rsp_valid_in = 1'b1;
               state_in     = tlic_pkg::S_IDLE;
            end else begin
               fwr_en = 1'b1;
               if (far_vv) begin
                  vaddr_in  = vaddr_new;
                  nrow_in   = rd_near_ff;
                  l2hit_in  = far_hit;
                  nrd_en    = 1'b1;
                  nrd_addr  = NIW'(vaddr_new % NEAR_SETS);
                  state_in  = tlic_pkg::S_INV;
               end else begin
                  nwr_en       = 1'b1;
                  rsp_valid_in = 1'b1;
                  state_in     = tlic_pkg::S_IDLE;
               end
            end
         end
         tlic_pkg::S_INV: begin
            nwr_en = 1'b1;
            if (vset == nset) begin
               rsp_valid_in = 1'b1;
               rsp_l2_in    = l2hit_ff;
               rsp_vv_in    = 1'b1;
               rsp_va_in    = vaddr_ff;
               state_in     = tlic_pkg::S_IDLE;
            end else begin
               nwr_addr = vset;
               nwr_data = inv_row;
               state_in = tlic_pkg::S_FILL;
            end
         end
         tlic_pkg::S_FILL: begin
            nwr_en       = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_l2_in    = l2hit_ff;
            rsp_vv_in    = 1'b1;
            rsp_va_in    = vaddr_ff;
            state_in     = tlic_pkg::S_IDLE;
         end
         default: state_in = tlic_pkg::S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tlic_pkg::S_CLEAR;
         policy_ff    <= tlic_pkg::POL_LRU;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         policy_ff    <= policy_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff   <= addr_in;
      vaddr_ff  <= vaddr_in;
      nrow_ff   <= nrow_in;
      l2hit_ff  <= l2hit_in;
      rsp_l1_ff <= rsp_l1_in;
      rsp_l2_ff <= rsp_l2_in;
      rsp_vv_ff <= rsp_vv_in;
      rsp_va_ff <= rsp_va_in;
   end

   always_ff @(posedge clock) begin
      if (nwr_en) near_mem[nwr_addr] <= nwr_data;
      if (nrd_en) rd_near_ff <= near_mem[nrd_addr];
   end

   always_ff @(posedge clock) begin
      if (fwr_en) far_mem[fwr_addr] <= fwr_data;
      if (frd_en) rd_far_ff <= far_mem[frd_addr];
   end

   assign busy               = (state_ff != tlic_pkg::S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_l1_hit         = rsp_l1_ff;
   assign rsp_l2_hit         = rsp_l2_ff;
   assign rsp_victim_valid   = rsp_vv_ff;
   assign rsp_victim_address = tlic_pkg::ADDR_PORT_BITS'(rsp_va_ff);

`ifndef ASSERT_OFF
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while still busy");
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held two cycles");
   a_hit_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_l1_hit && (rsp_l2_hit || rsp_victim_valid)))
      else $error("L1 hit with L2 activity");
   a_victim_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_victim_valid) |-> !rsp_l2_hit)
      else $error("eviction on an L2 hit");
`endif

endmodule
